[rtl/simhash128_signature_core_assert.svh]
// ----------------------------------------------------------------------------
// SimHash signature core assertion macros
// Shared concurrent assertion forms for the signature core RTL.
// ----------------------------------------------------------------------------
`ifndef SIMHASH128_SIGNATURE_CORE_ASSERT_SVH
`define SIMHASH128_SIGNATURE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SH128_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sh128 same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SH128_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sh128 next-cycle check failed");

`endif

[rtl/sh128_pkg.sv]
// ----------------------------------------------------------------------------
// SimHash signature package
// Hash constants, request kinds and the FNV-1a step shared by the core.
// ----------------------------------------------------------------------------
package sh128_pkg;

   localparam int HASH_BITS        = 64;
   localparam int SIG_BITS         = 2 * HASH_BITS;
   localparam int BYTE_BITS        = 8;
   localparam int WEIGHT_PORT_BITS = 32;
   localparam int WEIGHT_BITS_DEF  = 32;
   localparam int VOTE_BITS_DEF    = 48;

   localparam logic [HASH_BITS-1:0] FNV_BASIS = 64'd1469598103934665603;
   localparam logic [HASH_BITS-1:0] HIGH_SEED = 64'h9E3779B185EBCA87;
   localparam logic [HASH_BITS-1:0] HIGH_BASIS = FNV_BASIS ^ HIGH_SEED;

   typedef enum logic {
      OP_BYTE  = 1'b0,
      OP_CLOSE = 1'b1
   } op_type;

   typedef struct packed {
      logic vote;
      logic clear;
   } vote_cmd_type;

   // One FNV-1a step. The prime is 2^40 + 0x1B3, so the product is a short
   // sum of shifted copies.
   function automatic logic [HASH_BITS-1:0] fnv_step(input logic [HASH_BITS-1:0] h,
                                                     input logic [BYTE_BITS-1:0] b);
      logic [HASH_BITS-1:0] x;
      x = h ^ HASH_BITS'(b);
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

endpackage

[rtl/sh128_hasher.sv]
// ----------------------------------------------------------------------------
// SimHash dual FNV hasher
// Holds the low and high running hashes and advances both by one byte.
// ----------------------------------------------------------------------------
module sh128_hasher
   import sh128_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  op_type               op,
   input  logic [BYTE_BITS-1:0] token_byte,
   input  logic                 token_last,
   output logic [HASH_BITS-1:0] low_next,
   output logic [HASH_BITS-1:0] high_next
);

   logic [HASH_BITS-1:0] low_ff, low_in;
   logic [HASH_BITS-1:0] high_ff, high_in;

   assign low_next  = fnv_step(low_ff, token_byte);
   assign high_next = fnv_step(high_ff, token_byte);

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (step) begin
         // A finished token or a close starts both hashes over.
         if (op == OP_CLOSE || token_last) begin
            low_in  = FNV_BASIS;
            high_in = HIGH_BASIS;
         end else begin
            low_in  = low_next;
            high_in = high_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= FNV_BASIS;
         high_ff <= HIGH_BASIS;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

endmodule

[rtl/sh128_vote_bank.sv]
// ----------------------------------------------------------------------------
// SimHash vote bank
// Keeps one saturating signed counter per signature bit.
// ----------------------------------------------------------------------------
module sh128_vote_bank
   import sh128_pkg::*;
#(
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
   parameter int VOTE_BITS   = VOTE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  vote_cmd_type           cmd,
   input  logic [SIG_BITS-1:0]    hash_bits,
   input  logic [WEIGHT_BITS-1:0] weight,
   output logic [SIG_BITS-1:0]    signature
);

   localparam int SUM_BITS = ((VOTE_BITS > WEIGHT_BITS) ? VOTE_BITS : WEIGHT_BITS) + 2;
   localparam logic signed [VOTE_BITS-1:0] VMAX = {1'b0, {(VOTE_BITS-1){1'b1}}};
   localparam logic signed [VOTE_BITS-1:0] VMIN = {1'b1, {(VOTE_BITS-1){1'b0}}};
   localparam logic signed [SUM_BITS-1:0]  VMAX_EXT = SUM_BITS'(VMAX);
   localparam logic signed [SUM_BITS-1:0]  VMIN_EXT = SUM_BITS'(VMIN);

   logic signed [VOTE_BITS-1:0] votes_ff [SIG_BITS];
   logic signed [VOTE_BITS-1:0] votes_in [SIG_BITS];

   always_comb begin
      logic signed [SUM_BITS-1:0] ext_v;
      logic signed [SUM_BITS-1:0] ext_w;
      logic signed [SUM_BITS-1:0] total;
      ext_w = signed'(SUM_BITS'(weight));
      for (int i = 0; i < SIG_BITS; i++) begin
         ext_v = SUM_BITS'(votes_ff[i]);
         votes_in[i] = votes_ff[i];
         total = ext_v;
         if (cmd.clear) begin
            votes_in[i] = '0;
         end else if (cmd.vote) begin
            if (hash_bits[i]) begin
               total = ext_v + ext_w;
               votes_in[i] = (total > VMAX_EXT) ? VMAX : VOTE_BITS'(total);
            end else begin
               total = ext_v - ext_w;
               votes_in[i] = (total < VMIN_EXT) ? VMIN : VOTE_BITS'(total);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         votes_ff <= '{default: '0};
      end else if (cmd.vote || cmd.clear) begin
         votes_ff <= votes_in;
      end
   end

   // A bit is set when its counter is not negative.
   always_comb begin
      for (int i = 0; i < SIG_BITS; i++) begin
         signature[i] = ~votes_ff[i][VOTE_BITS-1];
      end
   end

endmodule

[rtl/simhash128_signature_core.sv]
// ----------------------------------------------------------------------------
// SimHash 128-bit signature core
// Streams token bytes with weights and emits a 128-bit SimHash per document.
// ----------------------------------------------------------------------------
// The core takes one request per clock cycle when the result side is not
// stalled. Each token byte advances two FNV-1a 64-bit hashes together. On a
// token's last byte the 128 vote counters are updated in parallel from the
// vote stage register. A close request passes the input and vote stage
// registers, returns its signature on rsp_tdata from the result register
// and clears the counters; byte requests return nothing. A held signature does
// not block further byte requests, only a second close behind it.
// ----------------------------------------------------------------------------
`include "simhash128_signature_core_assert.svh"

module simhash128_signature_core
   import sh128_pkg::*;
#(
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
   parameter int VOTE_BITS   = VOTE_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [39:0]   req_tdata,   // token_byte[7:0], token_weight[39:8]
   input  logic          req_tlast,
   input  logic          req_tuser,   // op[0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata    // signature_low[63:0], signature_high[127:64]
);

   localparam int WEIGHT_USE = (WEIGHT_BITS < WEIGHT_PORT_BITS) ? WEIGHT_BITS
                                                                : WEIGHT_PORT_BITS;

   // Input register.
   logic                  s0_valid_ff, s0_valid_in;
   op_type                s0_op_ff;
   logic [BYTE_BITS-1:0]  s0_byte_ff;
   logic                  s0_last_ff;
   logic [WEIGHT_USE-1:0] s0_weight_ff;

   // Vote stage register.
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_vote_ff;
   logic                  s1_close_ff;
   logic [SIG_BITS-1:0]   s1_hash_ff;
   logic [WEIGHT_USE-1:0] s1_weight_ff;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SIG_BITS-1:0]   rsp_sig_ff;

   logic                  out_free;
   logic                  s1_done;
   logic                  s1_open;
   logic                  s0_fire;
   logic                  req_fire;
   logic [HASH_BITS-1:0]  low_next;
   logic [HASH_BITS-1:0]  high_next;
   logic [SIG_BITS-1:0]   signature;
   vote_cmd_type          cmd;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_done    = s1_valid_ff && (!s1_close_ff || out_free);
   assign s1_open    = !s1_valid_ff || s1_done;
   assign s0_fire    = s0_valid_ff && s1_open;
   assign req_tready = !s0_valid_ff || s1_open;
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sig_ff;

   sh128_hasher u_hasher (
      .clock      (clock),
      .reset      (reset),
      .step       (s0_fire),
      .op         (s0_op_ff),
      .token_byte (s0_byte_ff),
      .token_last (s0_last_ff),
      .low_next   (low_next),
      .high_next  (high_next)
   );

   assign cmd.vote  = s1_done && s1_vote_ff;
   assign cmd.clear = s1_done && s1_close_ff;

   sh128_vote_bank #(
      .WEIGHT_BITS (WEIGHT_USE),
      .VOTE_BITS   (VOTE_BITS)
   ) u_vote_bank (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .hash_bits (s1_hash_ff),
      .weight    (s1_weight_ff),
      .signature (signature)
   );

   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (req_fire) begin
         s0_valid_in = 1'b1;
      end else if (s0_fire) begin
         s0_valid_in = 1'b0;
      end

      s1_valid_in = s1_valid_ff;
      if (s0_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.clear) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s0_op_ff     <= op_type'(req_tuser);
         s0_byte_ff   <= req_tdata[BYTE_BITS-1:0];
         s0_last_ff   <= req_tlast;
         s0_weight_ff <= req_tdata[BYTE_BITS +: WEIGHT_USE];
      end
      if (s0_fire) begin
         s1_vote_ff   <= (s0_op_ff == OP_BYTE) && s0_last_ff;
         s1_close_ff  <= (s0_op_ff == OP_CLOSE);
         s1_hash_ff   <= {high_next, low_next};
         s1_weight_ff <= s0_weight_ff;
      end
      if (cmd.clear) begin
         rsp_sig_ff <= signature;
      end
   end

   // Token items never wait in the vote stage.
   `SH128_ASSERT_SAME(a_token_never_stalls, clock, reset,
                      s1_valid_ff && !s1_close_ff, s1_done)
   // A close never overwrites a signature that is still waiting.
   `SH128_ASSERT_SAME(a_no_result_overwrite, clock, reset,
                      rsp_valid_ff && !rsp_tready, !cmd.clear)
   // A completed close always shows a result in the next cycle.
   `SH128_ASSERT_NEXT(a_close_gives_result, clock, reset, cmd.clear, rsp_valid_ff)
   // Vote and clear never happen together.
   `SH128_ASSERT_SAME(a_cmd_exclusive, clock, reset, cmd.vote, !cmd.clear)

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// SimHash signature core testbench
// Streams tokens and document closes into the core with random idling on both
// sides. A behavioral copy of the hashing and voting predicts each 128-bit
// signature, and every signature that comes back is compared field by field.
// ----------------------------------------------------------------------------
module tb
   import sh128_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WEIGHT_W      = 32;
   localparam int VOTE_W        = VOTE_BITS_DEF;
   localparam int RANDOM_ITEMS  = 1100;
   localparam int QUIET_TAIL    = 150;
   localparam int STALL_LIMIT   = 500;
   localparam int SETTLE_CYCLES = 10;

   localparam logic [63:0] OFFSET_BASIS = 64'd1469598103934665603;
   localparam logic [63:0] FNV_PRIME_64 = 64'h00000100000001B3;
   localparam logic [63:0] SEED_HIGH    = 64'h9E3779B185EBCA87;

   // Behavioral SimHash: two running FNV-1a hashes and 128 saturating votes.
   class simhash_predictor;
      logic [63:0]  low_hash;
      logic [63:0]  high_hash;
      longint       votes [128];
      logic [127:0] signatures_due [$];
      int           failures;

      function void restart_hashes();
         low_hash  = OFFSET_BASIS;
         high_hash = OFFSET_BASIS ^ SEED_HIGH;
      endfunction

      function void clear_state();
         restart_hashes();
         foreach (votes[i]) votes[i] = 0;
         signatures_due.delete();
         failures = 0;
      endfunction

      function void tally(int idx, bit up, longint w);
         longint vmax;
         longint vmin;
         longint v;
         vmax = (longint'(1) << (VOTE_W - 1)) - 1;
         vmin = -vmax - 1;
         v = votes[idx];
         if (up) begin
            v = (v > vmax - w) ? vmax : v + w;
         end else begin
            v = (v < vmin + w) ? vmin : v - w;
         end
         votes[idx] = v;
      endfunction

      function void note_request(op_type op, logic [7:0] data_byte, bit last,
                                 logic [31:0] weight);
         longint       w;
         logic [127:0] sig;
         if (op == OP_BYTE) begin
            low_hash  = (low_hash ^ {56'd0, data_byte}) * FNV_PRIME_64;
            high_hash = (high_hash ^ {56'd0, data_byte}) * FNV_PRIME_64;
            if (last) begin
               w = longint'(64'(weight)) & ((longint'(1) << WEIGHT_W) - 1);
               for (int i = 0; i < 64; i++) begin
                  tally(i, low_hash[i], w);
                  tally(i + 64, high_hash[i], w);
               end
               restart_hashes();
            end
         end else begin
            for (int i = 0; i < 128; i++) begin
               sig[i] = (votes[i] >= 0);
               votes[i] = 0;
            end
            signatures_due.insert(signatures_due.size(), sig);
            restart_hashes();
         end
      endfunction

      function void report(string what, logic [63:0] want, logic [63:0] got);
         if (failures < 10) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $realtime, what, want, got);
         end
         failures++;
      endfunction

      function void check_signature(logic [127:0] got);
         logic [127:0] want;
         if (signatures_due.size() == 0) begin
            if (failures < 10) begin
               $display("%0t: unexpected signature %h", $realtime, got);
            end
            failures++;
         end else begin
            want = signatures_due.pop_front();
            if (got[63:0] !== want[63:0]) begin
               report("signature_low", want[63:0], got[63:0]);
            end
            if (got[127:64] !== want[127:64]) begin
               report("signature_high", want[127:64], got[127:64]);
            end
         end
      endfunction

      function int pending();
         return signatures_due.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [39:0]  req_tdata = '0;   // token_byte[7:0], token_weight[39:8]
   logic         req_tlast = 1'b0;
   logic         req_tuser = 1'b0; // op[0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;        // signature_low[63:0], signature_high[127:64]

   simhash_predictor model;
   bit  idle_on = 1'b1;
   int  items_sent = 0;
   int  quiet_cycles = 0;
   int  stall_left = 0;

   simhash128_signature_core #(
      .WEIGHT_BITS(WEIGHT_W),
      .VOTE_BITS  (VOTE_W)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Result side: ready most of the time, with occasional stall bursts.
   initial begin
      forever begin
         @(negedge clock);
         if (reset || !idle_on) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 8);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         model.check_signature(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic send_request(op_type op, logic [7:0] data_byte, bit last,
                               logic [31:0] weight);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tdata  <= {weight, data_byte};
      req_tlast  <= last;
      req_tuser  <= op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      model.note_request(op, data_byte, last, weight);
      items_sent++;
   endtask

   task automatic send_token(int len, logic [31:0] weight, bit finish_it);
      for (int i = 0; i < len; i++) begin
         send_request(OP_BYTE, 8'($urandom),
                      finish_it && (i == len - 1),
                      (i == len - 1) ? weight : $urandom);
      end
   endtask

   task automatic send_close();
      send_request(OP_CLOSE, 8'($urandom), 1'($urandom), $urandom);
   endtask

   task automatic wait_for_signatures();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_weight();
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return $urandom_range(1, 16);
         default: return $urandom;
      endcase
   endfunction

   // One random document: mostly well-formed token lists with a close,
   // sometimes heavy repetition, a cut-off token, or plain noise.
   task automatic send_document();
      int          kind;
      int          len;
      logic [7:0]  text [4];
      logic [31:0] weight;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         repeat ($urandom_range(0, 10)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            send_token(len, pick_weight(), 1'b1);
         end
         send_close();
      end else if (kind < 80) begin
         len = $urandom_range(1, 4);
         foreach (text[i]) text[i] = 8'($urandom);
         weight = 32'hFFFF_FFFF - $urandom_range(0, 3);
         repeat ($urandom_range(8, 14)) begin
            for (int i = 0; i < len; i++) begin
               send_request(OP_BYTE, text[i], i == len - 1, weight);
            end
         end
         if ($urandom_range(0, 1) == 1) send_token($urandom_range(1, 4), pick_weight(), 1'b1);
         send_close();
      end else if (kind < 90) begin
         repeat ($urandom_range(0, 4)) send_token($urandom_range(1, 6), pick_weight(), 1'b1);
         send_token($urandom_range(1, 4), $urandom, 1'b0);
         send_close();
      end else begin
         repeat ($urandom_range(1, 8)) begin
            send_request(($urandom_range(0, 3) == 0) ? OP_CLOSE : OP_BYTE,
                         8'($urandom), 1'($urandom), $urandom);
         end
      end
   endtask

   initial begin
      int start;
      int next_drain;
      model = new;
      model.clear_state();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part.
      send_request(OP_CLOSE, 8'hFF, 1'b1, 32'hFFFF_FFFF);   // empty document
      send_request(OP_BYTE, 8'h00, 1'b1, 32'hFFFF_FFFF);
      send_request(OP_BYTE, 8'hFF, 1'b1, 32'd1);
      send_request(OP_BYTE, 8'h5A, 1'b0, 32'd7);
      send_request(OP_BYTE, 8'hA5, 1'b0, 32'd7);
      send_request(OP_BYTE, 8'h3C, 1'b1, 32'd0);            // zero weight
      send_request(OP_CLOSE, 8'h00, 1'b0, 32'd0);
      // The same token over and over builds large counts, then a different
      // token pulls some of them back.
      repeat (10) send_request(OP_BYTE, 8'hA5, 1'b1, 32'hFFFF_FFFF);
      send_request(OP_BYTE, 8'h11, 1'b1, 32'hFFFF_FFFF);
      send_request(OP_CLOSE, 8'h00, 1'b0, 32'd0);
      // A token cut off by the close must not leak into the next document.
      send_request(OP_BYTE, 8'h80, 1'b0, 32'h8000_0000);
      send_request(OP_BYTE, 8'h01, 1'b0, 32'h0000_0001);
      send_request(OP_CLOSE, 8'h7F, 1'b1, 32'h1234_5678);
      send_request(OP_BYTE, 8'h42, 1'b1, 32'd3);
      send_request(OP_CLOSE, 8'h00, 1'b0, 32'd0);
      wait_for_signatures();

      start = items_sent;
      next_drain = 300;
      while (items_sent - start < RANDOM_ITEMS) begin
         if (items_sent - start >= next_drain) begin
            wait_for_signatures();
            next_drain += 300;
         end
         if (items_sent - start >= RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
         send_document();
      end
      send_close();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (model.failures == 0 && model.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
